// ===== hdl/dtr_pkg.sv =====
// Package for the divider/timer block: item types, register addresses and codes.
// Shared by dtr_step and the top level; has no dependencies of its own.

package dtr_pkg;

    // Item opcodes.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;
    localparam logic [1:0] OP_PRESET = 2'd3;

    // Bus addresses of the timer registers.
    localparam logic [15:0] ADDR_DIVIDER = 16'hFF04;
    localparam logic [15:0] ADDR_COUNTER = 16'hFF05;
    localparam logic [15:0] ADDR_MODULO  = 16'hFF06;
    localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

    // Configuration register indexes.
    localparam logic CFG_DOUBLE_SPEED = 1'b0;
    localparam logic CFG_COLOR_MODEL  = 1'b1;

    localparam logic [7:0]  CONTROL_READ_SET = 8'hF8;
    localparam logic [7:0]  CONTROL_MASK     = 8'h07;
    localparam logic [15:0] PRESET_COLOR     = 16'h267B;
    localparam logic [15:0] PRESET_MONO      = 16'hABCB;
    localparam logic [2:0]  RELOAD_DELAY     = 3'd4;
    localparam logic [7:0]  COUNTER_MAX      = 8'hFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       accepted;
        logic       timer_irq;
        logic       apu_clock;
    } t_out_item;

    typedef struct packed {
        logic [15:0] system_count;
        logic [7:0]  timer_count;
        logic [7:0]  modulo_value;
        logic [2:0]  control_bits;
        logic [2:0]  overflow_wait;
        logic        reloaded_now;
    } t_timer_state;

    // Input of the falling-edge detector that drives the timer counter.
    function automatic logic timer_input(input logic [15:0] sys, input logic [2:0] ctrl);
        logic b;
        begin
            unique case (ctrl[1:0])
                2'd0: b = sys[9];
                2'd1: b = sys[3];
                2'd2: b = sys[5];
                2'd3: b = sys[7];
                default: b = 1'b0;
            endcase
            return ctrl[2] & b;
        end
    endfunction

    function automatic logic apu_input(input logic [15:0] sys, input logic dbl);
        return dbl ? sys[13] : sys[12];
    endfunction

endpackage

// ===== hdl/dtr_step.sv =====
// Next-state and result logic of the divider/timer for one item.
// Purely combinational; uses the types and helper functions of dtr_pkg.

module dtr_step (
    input  dtr_pkg::t_in_item     i_item,
    input  dtr_pkg::t_timer_state i_state,
    input  logic                  i_double_speed,
    input  logic                  i_color_model,
    output dtr_pkg::t_timer_state o_state,
    output dtr_pkg::t_out_item    o_result
);

    always_comb begin
        dtr_pkg::t_timer_state s;
        dtr_pkg::t_out_item    r;
        logic                  is_reg;
        logic                  bump;
        logic                  old_t;

        s      = i_state;
        r      = '0;
        bump   = 1'b0;
        old_t  = dtr_pkg::timer_input(i_state.system_count, i_state.control_bits);
        is_reg = (i_item.address >= dtr_pkg::ADDR_DIVIDER) &&
                 (i_item.address <= dtr_pkg::ADDR_CONTROL);

        unique case (i_item.opcode)
            dtr_pkg::OP_TICK: begin
                r.accepted     = 1'b1;
                s.reloaded_now = 1'b0;
                if (i_state.overflow_wait != 3'd0) begin
                    s.overflow_wait = i_state.overflow_wait - 3'd1;
                    if (i_state.overflow_wait == 3'd1) begin
                        s.timer_count  = i_state.modulo_value;
                        s.reloaded_now = 1'b1;
                        r.timer_irq    = 1'b1;
                    end
                end
                s.system_count = i_state.system_count + 16'd1;
                bump = old_t &&
                       !dtr_pkg::timer_input(s.system_count, s.control_bits);
                r.apu_clock =
                    dtr_pkg::apu_input(i_state.system_count, i_double_speed) &&
                    !dtr_pkg::apu_input(s.system_count, i_double_speed);
            end
            dtr_pkg::OP_READ: begin
                if (is_reg) begin
                    r.accepted = 1'b1;
                    priority if (i_item.address == dtr_pkg::ADDR_DIVIDER)
                        r.read_data = i_state.system_count[15:8];
                    else if (i_item.address == dtr_pkg::ADDR_COUNTER)
                        r.read_data = i_state.timer_count;
                    else if (i_item.address == dtr_pkg::ADDR_MODULO)
                        r.read_data = i_state.modulo_value;
                    else
                        r.read_data = {5'b0, i_state.control_bits} |
                                      dtr_pkg::CONTROL_READ_SET;
                end
            end
            dtr_pkg::OP_WRITE: begin
                if (is_reg) begin
                    r.accepted = 1'b1;
                    priority if (i_item.address == dtr_pkg::ADDR_DIVIDER) begin
                        // Clearing the counter drops every bit, so any set input falls.
                        s.system_count = '0;
                        bump           = old_t;
                        r.apu_clock    = dtr_pkg::apu_input(i_state.system_count,
                                                            i_double_speed);
                    end else if (i_item.address == dtr_pkg::ADDR_COUNTER) begin
                        if (!i_state.reloaded_now) begin
                            s.timer_count   = i_item.write_data;
                            s.overflow_wait = '0;
                        end
                    end else if (i_item.address == dtr_pkg::ADDR_MODULO) begin
                        s.modulo_value = i_item.write_data;
                        if (i_state.reloaded_now)
                            s.timer_count = i_item.write_data;
                    end else begin
                        s.control_bits = 3'(i_item.write_data & dtr_pkg::CONTROL_MASK);
                        bump = old_t &&
                               !dtr_pkg::timer_input(s.system_count, s.control_bits);
                    end
                end
            end
            dtr_pkg::OP_PRESET: begin
                r.accepted     = 1'b1;
                s.system_count = i_color_model ? dtr_pkg::PRESET_COLOR
                                               : dtr_pkg::PRESET_MONO;
            end
            default: ;
        endcase

        // Counter increment; suppressed while a reload is pending or just happened.
        if (bump && (s.overflow_wait == 3'd0) && !s.reloaded_now) begin
            if (s.timer_count == dtr_pkg::COUNTER_MAX) begin
                s.timer_count   = '0;
                s.overflow_wait = dtr_pkg::RELOAD_DELAY;
            end else begin
                s.timer_count = s.timer_count + 8'd1;
            end
        end

        o_state  = s;
        o_result = r;
    end

endmodule

// ===== hdl/divider_timer_with_reload_delay.sv =====
// Top level of the divider/timer block with delayed overflow reload.
// Depends on dtr_pkg (types, constants) and dtr_step (per-item logic).

// Usage:
// The input channel (i_in_valid, o_in_stall, i_in) carries items: a tick,
// a register read, a register write or a boot preset. Every item yields
// exactly one result item on the output channel (o_out_valid, i_out_stall,
// o_out) holding read data, an accepted flag, the timer interrupt pulse
// and the APU clock pulse.
// An item accepted at a clock edge sits in the input register; once the
// output register is free or drains, the item is processed against the
// timer state and its result is visible in the output register from then
// on. One item is taken per cycle while the receiver does not stall; the
// rate is bounded by the single state update per item in the dtr_step logic.
// When the receiver stalls, the result holds in the output register, the
// next item waits in the input register, and o_in_stall rises only once
// both registers are occupied.
// The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) sets the
// double-speed and color-model bits; write it only while the block is idle.
// Synchronous reset empties both pipeline registers (their payloads are
// not reset) and clears the configuration and all timer state to zero.

module divider_timer_with_reload_delay (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  dtr_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dtr_pkg::t_out_item o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic              i_cfg_data
);

    logic                  r_in_valid;
    dtr_pkg::t_in_item     r_in;
    logic                  r_out_valid;
    dtr_pkg::t_out_item    r_out;
    dtr_pkg::t_timer_state r_state;
    dtr_pkg::t_timer_state n_state;
    dtr_pkg::t_out_item    n_out;
    logic                  r_double_speed;
    logic                  r_color_model;
    logic                  advance;
    logic                  in_take;

    // The held item moves on whenever the output register is free or drains.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    dtr_step u_step (
        .i_item         (r_in),
        .i_state        (r_state),
        .i_double_speed (r_double_speed),
        .i_color_model  (r_color_model),
        .o_state        (n_state),
        .o_result       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_state        <= '0;
            r_double_speed <= 1'b0;
            r_color_model  <= 1'b0;
        end else begin
            if (in_take)
                r_in_valid <= 1'b1;
            else if (advance)
                r_in_valid <= 1'b0;

            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dtr_pkg::CFG_DOUBLE_SPEED: r_double_speed <= i_cfg_data;
                    dtr_pkg::CFG_COLOR_MODEL:  r_color_model  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take)
            r_in <= i_in;
        if (advance)
            r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hdl/dtr_checker.sv =====
// Port-level checks for the divider/timer block, bound to the top level.
// Depends on dtr_pkg for the result item type.

module dtr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input dtr_pkg::t_out_item o_out
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Interrupts come only from ticks, which are always accepted.
    a_irq_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.timer_irq |-> o_out.accepted)
        else $error("timer interrupt on an unaccepted item");

    a_apu_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.apu_clock |-> o_out.accepted)
        else $error("APU clock on an unaccepted item");

    // Read data only on reads, which never pulse the interrupt or APU clock.
    a_read_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.read_data != 8'd0) |->
            o_out.accepted && !o_out.timer_irq && !o_out.apu_clock)
        else $error("read data together with a tick pulse");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind divider_timer_with_reload_delay dtr_checker u_dtr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ===== test/timer_shadow_pkg.sv =====
// Software copy of the divider/timer block that predicts one result item per input item.
// Depends on dtr_pkg for the item types, the register addresses and the constants.

package timer_shadow_pkg;

    import dtr_pkg::*;

    class timer_shadow;
        bit          dbl_speed;
        bit          color_boot;
        logic [15:0] sys_count;
        logic [7:0]  tima;
        logic [7:0]  tma;
        logic [2:0]  tac;
        logic [2:0]  reload_wait;
        bit          reload_tick;
        int unsigned taps[4] = '{9, 3, 5, 7};
        t_out_item   owed_results[$];
        int          fault_count;

        function new();
            dbl_speed   = 1'b0;
            color_boot  = 1'b0;
            sys_count   = '0;
            tima        = '0;
            tma         = '0;
            tac         = '0;
            reload_wait = '0;
            reload_tick = 1'b0;
            fault_count = 0;
        endfunction

        function void set_register(logic idx, logic val);
            if (idx == CFG_DOUBLE_SPEED) begin
                dbl_speed = val;
            end else begin
                color_boot = val;
            end
        endfunction

        // Level of the divider tap that clocks the timer counter.
        function bit counter_level();
            return tac[2] && sys_count[taps[tac[1:0]]];
        endfunction

        function bit frame_level();
            return dbl_speed ? sys_count[13] : sys_count[12];
        endfunction

        // Increments are lost while a reload is pending or was just done.
        function void bump_counter();
            if (reload_wait != 3'd0 || reload_tick) begin
                return;
            end
            if (tima == COUNTER_MAX) begin
                tima        = 8'd0;
                reload_wait = RELOAD_DELAY;
            end else begin
                tima++;
            end
        endfunction

        function void take_item(t_in_item it);
            t_out_item r;
            bit        was_t;
            bit        was_f;
            bit        is_reg;
            r      = '0;
            is_reg = (it.address >= ADDR_DIVIDER) && (it.address <= ADDR_CONTROL);
            case (it.opcode)
                OP_TICK: begin
                    r.accepted  = 1'b1;
                    reload_tick = 1'b0;
                    if (reload_wait != 3'd0) begin
                        reload_wait--;
                        if (reload_wait == 3'd0) begin
                            tima        = tma;
                            reload_tick = 1'b1;
                            r.timer_irq = 1'b1;
                        end
                    end
                    was_t = counter_level();
                    was_f = frame_level();
                    sys_count++;
                    if (was_t && !counter_level()) begin
                        bump_counter();
                    end
                    r.apu_clock = was_f && !frame_level();
                end
                OP_READ: begin
                    if (is_reg) begin
                        r.accepted = 1'b1;
                        case (it.address)
                            ADDR_DIVIDER: r.read_data = sys_count[15:8];
                            ADDR_COUNTER: r.read_data = tima;
                            ADDR_MODULO:  r.read_data = tma;
                            default:      r.read_data = CONTROL_READ_SET | {5'd0, tac};
                        endcase
                    end
                end
                OP_WRITE: begin
                    if (is_reg) begin
                        r.accepted = 1'b1;
                        was_t      = counter_level();
                        case (it.address)
                            ADDR_DIVIDER: begin
                                r.apu_clock = frame_level();
                                sys_count   = '0;
                            end
                            ADDR_COUNTER: begin
                                if (!reload_tick) begin
                                    tima        = it.write_data;
                                    reload_wait = 3'd0;
                                end
                            end
                            ADDR_MODULO: begin
                                tma = it.write_data;
                                if (reload_tick) begin
                                    tima = it.write_data;
                                end
                            end
                            default: tac = it.write_data[2:0];
                        endcase
                        if (was_t && !counter_level()) begin
                            bump_counter();
                        end
                    end
                end
                default: begin
                    r.accepted = 1'b1;
                    sys_count  = color_boot ? PRESET_COLOR : PRESET_MONO;
                end
            endcase
            owed_results.push_back(r);
        endfunction

        function void match_result(t_out_item got);
            t_out_item want;
            if (owed_results.size() == 0) begin
                $error("result item with nothing outstanding: %p", got);
                fault_count++;
                return;
            end
            want = owed_results.pop_front();
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %02h, actual %02h", want.read_data, got.read_data);
                fault_count++;
            end
            if (got.accepted !== want.accepted) begin
                $error("accepted: expected %0b, actual %0b", want.accepted, got.accepted);
                fault_count++;
            end
            if (got.timer_irq !== want.timer_irq) begin
                $error("timer_irq: expected %0b, actual %0b", want.timer_irq, got.timer_irq);
                fault_count++;
            end
            if (got.apu_clock !== want.apu_clock) begin
                $error("apu_clock: expected %0b, actual %0b", want.apu_clock, got.apu_clock);
                fault_count++;
            end
        endfunction
    endclass

endpackage

// ===== test/testbench.sv =====
// Self-checking testbench for divider_timer_with_reload_delay.
// Depends on dtr_pkg for the port types and on timer_shadow_pkg for the prediction.

module testbench;

    import dtr_pkg::*;
    import timer_shadow_pkg::*;

    // Cycles with no handshake on either channel before the run is declared hung.
    // The slowest correct stretch is the long receiver hold plus a sender gap.
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASE_ITEMS  = 120;
    localparam int DRAIN_CYCLES = 8;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_index = 1'b0;
    logic      i_cfg_data  = 1'b0;

    timer_shadow shadow;
    int          idle_pct     = 0;     // chance in percent of an idle burst on either side
    bit          quiet_tail   = 1'b0;  // set for the closing part: no idling at all
    bit          hold_wanted  = 1'b0;  // asks the receiver for one long hold-off
    int          quiet_cycles = 0;
    int          items_sent   = 0;

    divider_timer_with_reload_delay DUT (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Results are taken at the rising edge; the shadow pops the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            shadow.match_result(o_out);
        end
    end

    // Watchdog: any handshake on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("divider_timer_with_reload_delay regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver. It stalls in random bursts, and once on request holds off long
    // enough that both pipeline registers fill and the block stalls its input.
    initial begin : result_sink
        int burst;
        forever begin
            @(negedge i_clk);
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
                burst = $urandom_range(1, 14);
                i_out_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_in_item pack_item(logic [1:0] op, logic [15:0] addr,
                                           logic [7:0] data);
        t_in_item it;
        it.opcode     = op;
        it.address    = addr;
        it.write_data = data;
        return it;
    endfunction

    function automatic logic [15:0] any_timer_reg();
        return ADDR_DIVIDER + 16'($urandom_range(0, 3));
    endfunction

    function automatic t_in_item tick_item();
        return pack_item(OP_TICK, 16'($urandom), 8'($urandom));
    endfunction

    // Control bytes lean toward an enabled timer on the fast tap, so that
    // overflows and reloads come often.
    function automatic logic [7:0] control_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(0, 99) < 85) begin
            v[2] = 1'b1;
        end
        if (v[1:0] == 2'd0 && $urandom_range(0, 3) != 0) begin
            v[1:0] = 2'd1;
        end
        return v;
    endfunction

    // One item inside a timer sequence. The shadow state is current here, since
    // every earlier item has been accepted, so writes can be aimed at the reload
    // tick and at the wait before it.
    function automatic t_in_item episode_item();
        int unsigned roll;
        logic [7:0]  data;
        roll = $urandom_range(0, 99);
        data = 8'($urandom);
        if (shadow.reload_tick && roll < 50) begin
            return pack_item(OP_WRITE, (roll < 25) ? ADDR_COUNTER : ADDR_MODULO, data);
        end
        if (shadow.reload_wait != 3'd0 && roll < 24) begin
            case (roll % 3)
                0:       return pack_item(OP_WRITE, ADDR_DIVIDER, data);
                1:       return pack_item(OP_WRITE, ADDR_CONTROL, data);
                default: return pack_item(OP_WRITE, ADDR_COUNTER, data);
            endcase
        end
        if (roll < 78) begin
            return tick_item();
        end
        if (roll < 90) begin
            return pack_item(OP_READ, any_timer_reg(), data);
        end
        if (roll < 96) begin
            return pack_item(OP_WRITE, (roll < 93) ? ADDR_COUNTER : ADDR_MODULO, data);
        end
        if (roll < 98) begin
            return pack_item(OP_WRITE, ADDR_CONTROL, control_byte());
        end
        return pack_item(OP_WRITE, ADDR_DIVIDER, data);
    endfunction

    // Offers one item and returns just after the falling edge that follows its
    // acceptance. Valid stays high into the next call, so back-to-back items
    // never see valid dropped and raised in one time step.
    task automatic send_item(input t_in_item it);
        int gap;
        if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        shadow.take_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every owed result has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (shadow.owed_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_setting(input logic idx, input logic val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        shadow.set_register(idx, val);
    endtask

    // A well-formed timer sequence: set control, modulo and a counter close to
    // overflow, then mostly ticks with register traffic mixed in.
    task automatic timer_episode();
        logic [7:0] mod_val;
        int         span;
        mod_val = ($urandom_range(0, 1) != 0) ? (8'hF8 | 8'($urandom_range(0, 7)))
                                              : 8'($urandom);
        send_item(pack_item(OP_WRITE, ADDR_CONTROL, control_byte()));
        send_item(pack_item(OP_WRITE, ADDR_MODULO, mod_val));
        send_item(pack_item(OP_WRITE, ADDR_COUNTER, 8'hFC | 8'($urandom_range(0, 3))));
        span = $urandom_range(30, 80);
        repeat (span) send_item(episode_item());
    endtask

    // Unstructured items: any opcode, half of them at random addresses.
    task automatic noise_burst();
        logic [15:0] addr;
        int          count;
        count = $urandom_range(3, 8);
        repeat (count) begin
            addr = ($urandom_range(0, 1) != 0) ? any_timer_reg() : 16'($urandom);
            send_item(pack_item(2'($urandom), addr, 8'($urandom)));
        end
    endtask

    task automatic run_phase(input bit dbl, input bit color, input int pct,
                             input bit with_hold);
        int stop_at;
        settle();
        write_setting(CFG_DOUBLE_SPEED, dbl);
        write_setting(CFG_COLOR_MODEL, color);
        idle_pct = pct;
        if (with_hold) begin
            hold_wanted = 1'b1;
        end
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 15) begin
                noise_burst();
            end else begin
                timer_episode();
            end
        end
    endtask

    // Directed opening, run with double speed on and the mono preset, no idling.
    // It walks one overflow through the wait and the reload by hand.
    task automatic directed_items();
        send_item(pack_item(OP_TICK, 16'h0000, 8'h00));
        send_item(pack_item(OP_READ, ADDR_DIVIDER, 8'hFF));
        send_item(pack_item(OP_PRESET, 16'hFFFF, 8'hFF));
        send_item(pack_item(OP_READ, ADDR_DIVIDER, 8'h00));
        // Divider write while bit 13 is set pulses the APU clock.
        send_item(pack_item(OP_WRITE, ADDR_DIVIDER, 8'hFF));
        // Foreign addresses on both sides of the register window and at the ends.
        send_item(pack_item(OP_READ, 16'h0000, 8'h00));
        send_item(pack_item(OP_WRITE, 16'hFFFF, 8'hFF));
        send_item(pack_item(OP_READ, 16'hFF03, 8'hFF));
        send_item(pack_item(OP_WRITE, 16'hFF08, 8'h00));
        // The preset leaves bit 3 set, so disabling the timer makes a falling edge.
        send_item(pack_item(OP_PRESET, 16'h0000, 8'h00));
        send_item(pack_item(OP_WRITE, ADDR_CONTROL, 8'hFD));
        send_item(pack_item(OP_WRITE, ADDR_COUNTER, 8'hFF));
        send_item(pack_item(OP_WRITE, ADDR_MODULO, 8'hA5));
        send_item(pack_item(OP_WRITE, ADDR_CONTROL, 8'h01));
        // The counter now overflows and reads zero while the reload waits.
        send_item(pack_item(OP_TICK, 16'hFFFF, 8'hFF));
        send_item(pack_item(OP_READ, ADDR_COUNTER, 8'h00));
        send_item(pack_item(OP_WRITE, ADDR_CONTROL, 8'h05));
        // A divider write makes another falling edge, lost during the wait.
        send_item(pack_item(OP_WRITE, ADDR_DIVIDER, 8'h00));
        send_item(pack_item(OP_TICK, 16'h0000, 8'h00));
        send_item(pack_item(OP_TICK, 16'h0000, 8'h00));
        // Reload tick: interrupt, then a counter write that is ignored and a
        // modulo write that also lands in the counter.
        send_item(pack_item(OP_TICK, 16'h0000, 8'h00));
        send_item(pack_item(OP_WRITE, ADDR_COUNTER, 8'h00));
        send_item(pack_item(OP_WRITE, ADDR_MODULO, 8'h5A));
        send_item(pack_item(OP_READ, ADDR_CONTROL, 8'h00));
        send_item(pack_item(OP_READ, ADDR_MODULO, 8'h00));
        send_item(pack_item(OP_READ, ADDR_COUNTER, 8'h00));
    endtask

    initial begin : stimulus
        shadow = new();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_setting(CFG_DOUBLE_SPEED, 1'b1);
        write_setting(CFG_COLOR_MODEL, 1'b0);
        directed_items();
        // Random phases cover every setting of both registers. The first one
        // carries the long receiver hold-off.
        run_phase(1'b0, 1'b1, 10, 1'b1);
        run_phase(1'b1, 1'b1, 30, 1'b0);
        run_phase(1'b0, 1'b0, 0, 1'b0);
        run_phase(1'b1, 1'b0, 20, 1'b0);
        quiet_tail = 1'b1;
        run_phase(1'b0, 1'b1, 0, 1'b0);
        settle();
        if (shadow.fault_count == 0) begin
            $display("divider_timer_with_reload_delay regression: pass");
        end else begin
            $display("divider_timer_with_reload_delay regression: fail");
        end
        $finish;
    end

endmodule

// ===== divider_timer_with_reload_delay.f =====
hdl/dtr_pkg.sv
hdl/dtr_step.sv
hdl/divider_timer_with_reload_delay.sv
hdl/dtr_checker.sv
test/timer_shadow_pkg.sv
test/testbench.sv
